FILE: rtl/cmf_pkg.sv
package cmf_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int SUM_W       = 11;
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 14;
    localparam int CMD_DEPTH   = 4;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_LEVEL_W = $clog2(OUT_DEPTH + 1);

    // floor(s / 5) == (s * RECIP) >> RECIP_SHIFT for every s below 16384
    localparam logic [RECIP_W-1:0] RECIP = 12'd3277;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic drain;
        logic produce;
        logic pass;
        logic last;
    } cmd_flags_t;

endpackage

FILE: rtl/cmf_ram.sv
module cmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/cmf_queue.sv
module cmf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [LW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == LW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + LW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - LW'(1);
            end
        end
    end

endmodule

FILE: rtl/cmf_front.sv
module cmf_front import cmf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic                         action,
    input  logic [PIX_W-1:0]             pixel_in,
    input  logic                         cmd_full,
    output logic                         cmd_push,
    output cmd_flags_t                   cmd_flags,
    output logic [$clog2(MAX_WIDTH)-1:0] cmd_col,
    output logic [PIX_W-1:0]             cmd_pix
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [RW-1:0]    row_reg;
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    drain_reg;

    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic          wrap;
    logic [RW-1:0] r0;
    logic [CW-1:0] c0;
    logic [CW-1:0] d0;
    logic [CW-1:0] c_inc;
    logic [RW-1:0] r_inc;
    logic [RW-1:0] r_m1;
    logic [CW-1:0] d_inc;
    logic          drain_ok;
    logic          accept;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = RW'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = RW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = RW'(height_reg);
        end
    end

    // a pixel after a finished or pending frame starts a new one
    assign wrap     = (row_reg >= h_eff) || (col_reg >= w_eff);
    assign r0       = wrap ? '0 : row_reg;
    assign c0       = wrap ? '0 : col_reg;
    assign d0       = wrap ? '0 : drain_reg;
    assign c_inc    = c0 + CW'(1);
    assign r_inc    = r0 + RW'(1);
    assign r_m1     = r0 - RW'(1);
    assign d_inc    = drain_reg + CW'(1);
    assign drain_ok = (row_reg == h_eff) && (drain_reg < w_eff);

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_push = accept && ((action == ACT_PIXEL) || drain_ok);
    assign cmd_pix  = pixel_in;

    always_comb
    begin
        cmd_flags = '0;
        if (action == ACT_DRAIN)
        begin
            cmd_flags.drain = 1'b1;
            cmd_flags.last  = (drain_reg == w_eff - CW'(1));
            cmd_col         = drain_reg[AW-1:0];
        end
        else
        begin
            cmd_flags.produce = (r0 != '0);
            cmd_flags.pass    = (r_m1 == '0) || (r_m1 == h_eff - RW'(1))
                             || (c0 == '0) || (c0 == w_eff - CW'(1));
            cmd_col           = c0[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            row_reg    <= '0;
            col_reg    <= '0;
            drain_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
            row_reg   <= '0;
            col_reg   <= '0;
            drain_reg <= '0;
        end
        else if (accept)
        begin
            if (action == ACT_DRAIN)
            begin
                if (drain_ok)
                begin
                    if (d_inc >= w_eff)
                    begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        drain_reg <= '0;
                    end
                    else
                    begin
                        drain_reg <= d_inc;
                    end
                end
            end
            else if (c_inc >= w_eff)
            begin
                col_reg   <= '0;
                row_reg   <= r_inc;
                drain_reg <= '0;
            end
            else
            begin
                col_reg   <= c_inc;
                row_reg   <= r0;
                drain_reg <= d0;
            end
        end
    end

endmodule

FILE: rtl/cmf_back.sv
module cmf_back import cmf_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_empty,
    input  cmd_flags_t                   cmd_flags,
    input  logic [$clog2(MAX_WIDTH)-1:0] cmd_col,
    input  logic [PIX_W-1:0]             cmd_pix,
    output logic                         cmd_pop,
    input  logic [OUT_LEVEL_W-1:0]       out_level,
    input  logic                         out_pop_fire,
    output logic                         res_push,
    output logic [PIX_W-1:0]             res_pixel,
    output logic                         res_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LW = OUT_LEVEL_W + 1;
    localparam int PW = SUM_W + RECIP_W;

    logic             take;
    logic [LW-1:0]    in_flight;
    logic [LW-1:0]    limit;
    logic [AW-1:0]    right_col;
    logic [PIX_W-1:0] up_rd;
    logic [PIX_W-1:0] mid_rd;
    logic [PIX_W-1:0] right_rd;

    logic             s1_valid_reg;
    cmd_flags_t       s1_flags_reg;
    logic [AW-1:0]    s1_col_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [PIX_W-1:0] left_reg;
    logic             s1_prod;
    logic             s1_write;
    logic [SUM_W-1:0] s1_sum;

    logic             s2_valid_reg;
    logic             s2_pass_reg;
    logic             s2_last_reg;
    logic [PIX_W-1:0] s2_val_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic [PW-1:0]    s2_prod;

    // results in flight and queued must fit the result queue
    assign in_flight = LW'(out_level) + LW'(s1_prod) + LW'(s2_valid_reg);
    assign limit     = LW'(OUT_DEPTH) + LW'(out_pop_fire);
    assign take      = !cmd_empty && (in_flight < limit);
    assign cmd_pop   = take;
    assign right_col = cmd_col + AW'(1);

    cmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_a (
        .clk   (clk),
        .we    (take && !cmd_flags.drain),
        .waddr (cmd_col),
        .wdata (cmd_pix),
        .re    (take),
        .raddr (cmd_col),
        .rdata (mid_rd)
    );

    cmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_b (
        .clk   (clk),
        .we    (take && !cmd_flags.drain),
        .waddr (cmd_col),
        .wdata (cmd_pix),
        .re    (take),
        .raddr (right_col),
        .rdata (right_rd)
    );

    cmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (s1_write),
        .waddr (s1_col_reg),
        .wdata (mid_rd),
        .re    (take),
        .raddr (cmd_col),
        .rdata (up_rd)
    );

    assign s1_prod  = s1_valid_reg && (s1_flags_reg.drain || s1_flags_reg.produce);
    assign s1_write = s1_valid_reg && !s1_flags_reg.drain;
    assign s1_sum   = SUM_W'(up_rd) + SUM_W'(s1_pix_reg) + SUM_W'(left_reg)
                    + SUM_W'(mid_rd) + SUM_W'(right_rd);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_flags_reg <= cmd_flags;
            s1_col_reg   <= cmd_col;
            s1_pix_reg   <= cmd_pix;
        end
        if (s1_prod)
        begin
            s2_pass_reg <= s1_flags_reg.drain || s1_flags_reg.pass;
            s2_last_reg <= s1_flags_reg.last;
            s2_val_reg  <= mid_rd;
            s2_sum_reg  <= s1_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_prod;
            if (s1_write)
            begin
                left_reg <= mid_rd;
            end
        end
    end

    // divide by five through the reciprocal
    assign s2_prod   = PW'(s2_sum_reg) * PW'(RECIP);
    assign res_push  = s2_valid_reg;
    assign res_last  = s2_last_reg;
    assign res_pixel = s2_pass_reg ? s2_val_reg : s2_prod[RECIP_SHIFT +: PIX_W];

endmodule

FILE: rtl/cross_mean_image_filter_core.sv
// channel  | handshake         | beat
// ---------+-------------------+----------------------------------------
// input    | push / full       | action, pixel_in
// result   | pop / empty       | pixel_out, last_of_frame
// config   | cfg_we            | cfg_index, cfg_data
//
// one beat a cycle in and out while full and empty stay low; a result reaches the
// result queue through the command queue, the row store read and the divider stage
// the row stores are single-write rams with registered read, no clearing pass
// after reset; full rises only when the result queue backs up into the
// command queue
module cross_mean_image_filter_core import cmf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             push,
    output logic             full,
    input  logic             action,
    input  logic [PIX_W-1:0] pixel_in,
    output logic             empty,
    input  logic             pop,
    output logic [PIX_W-1:0] pixel_out,
    output logic             last_of_frame
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CMD_W = $bits(cmd_flags_t) + AW + PIX_W;
    localparam int RES_W = PIX_W + 1;

    logic                   cmd_full;
    logic                   cmd_push;
    cmd_flags_t             cmd_flags_in;
    logic [AW-1:0]          cmd_col_in;
    logic [PIX_W-1:0]       cmd_pix_in;
    logic [CMD_W-1:0]       cmd_rdata;
    logic                   cmd_empty;
    logic                   cmd_pop;
    cmd_flags_t             cmd_flags_out;
    logic [AW-1:0]          cmd_col_out;
    logic [PIX_W-1:0]       cmd_pix_out;
    logic [OUT_LEVEL_W-1:0] out_level;
    logic                   res_push;
    logic [PIX_W-1:0]       res_pixel;
    logic                   res_last;
    logic                   res_full;

    cmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .action    (action),
        .pixel_in  (pixel_in),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_flags (cmd_flags_in),
        .cmd_col   (cmd_col_in),
        .cmd_pix   (cmd_pix_in)
    );

    cmf_queue #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata ({cmd_flags_in, cmd_col_in, cmd_pix_in}),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty),
        .level ()
    );

    assign {cmd_flags_out, cmd_col_out, cmd_pix_out} = cmd_rdata;

    cmf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmd_empty),
        .cmd_flags    (cmd_flags_out),
        .cmd_col      (cmd_col_out),
        .cmd_pix      (cmd_pix_out),
        .cmd_pop      (cmd_pop),
        .out_level    (out_level),
        .out_pop_fire (pop && !empty),
        .res_push     (res_push),
        .res_pixel    (res_pixel),
        .res_last     (res_last)
    );

    cmf_queue #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push && !res_full),
        .wdata ({res_pixel, res_last}),
        .full  (res_full),
        .pop   (pop),
        .rdata ({pixel_out, last_of_frame}),
        .empty (empty),
        .level (out_level)
    );

endmodule

FILE: rtl/cmf_checker.sv
module cmf_checker import cmf_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             push,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic [PIX_W-1:0] pixel_out,
    input logic             last_of_frame
);

    // held result beat stays put until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_out) && $stable(last_of_frame)))
        else $error("result beat changed while stalled");

    a_reset_state: assert property (@(posedge clk)
        (!rst_n ##1 !rst_n) |-> (empty && !full))
        else $error("queues not cleared in reset");

    // input backs up only behind waiting results
    a_full_needs_results: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input stalled with no result waiting");

    a_no_accept_in_reset: assert property (@(posedge clk)
        (!rst_n && push) |-> !full)
        else $error("full raised during reset");

endmodule

bind cross_mean_image_filter_core cmf_checker u_checker (.*);
